// ===== design/joint_pd_torque_with_softstop_macros.svh =====
// Assertion macros for the joint PD torque block and its port checker.
// Needs nothing else; included by the checker file.
`ifndef JOINT_PD_TORQUE_WITH_SOFTSTOP_MACROS_SVH
`define JOINT_PD_TORQUE_WITH_SOFTSTOP_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define JPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, masked while reset is asserted
`define JPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// ===== design/jpd_pkg.sv =====
// Shared widths, codes and pipeline item types for the joint PD torque block.
// No dependencies; every other design file but the macro header refers to it by scoped names.
`default_nettype none

package jpd_pkg;

	// Field widths
	localparam int DATA_WIDTH  = 16;
	localparam int JOINT_COUNT = 3;
	localparam int JOINT_W     = 2;
	localparam int GAIN_W      = 16;
	localparam int LIM_W       = 16;
	localparam int POS_LIM_W   = 32;
	localparam int TRQ_LIM_W   = 48;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_W       = 48;

	// Arithmetic widths: errors, products, Q.20 accumulator, rounded torque
	localparam int ERR_W   = DATA_WIDTH + 1;
	localparam int PROD_W  = ERR_W + GAIN_W + 1;
	localparam int VEL_SH  = 4;
	localparam int RND_SH  = 12;
	localparam int ACC_W   = PROD_W + VEL_SH + 2;
	localparam int T_W     = ACC_W - RND_SH;

	// Stream packing: input tdata fields from the lowest bit up
	localparam int POS_LO   = 0;
	localparam int VEL_LO   = POS_LO + DATA_WIDTH;
	localparam int KP_LO    = VEL_LO + DATA_WIDTH;
	localparam int KD_LO    = KP_LO + GAIN_W;
	localparam int QDES_LO  = KD_LO + GAIN_W;
	localparam int VDES_LO  = QDES_LO + DATA_WIDTH;
	localparam int FF_LO    = VDES_LO + DATA_WIDTH;
	localparam int S_BITS   = FF_LO + DATA_WIDTH;
	localparam int S_DATA_W = ((S_BITS + 7) / 8) * 8;
	localparam int S_USER_W = JOINT_W + 2;
	localparam int EN_BIT   = JOINT_W;
	localparam int WEAK_BIT = JOINT_W + 1;
	localparam int M_DATA_W = ((DATA_WIDTH + 7) / 8) * 8;

	// Joint codes
	localparam logic [JOINT_W-1:0] JOINT_ABAD = JOINT_W'(0);
	localparam logic [JOINT_W-1:0] JOINT_HIP  = JOINT_W'(1);
	localparam logic [JOINT_W-1:0] JOINT_KNEE = JOINT_W'(2);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SS_STIFF = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SS_DAMP  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_UPPER    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_LOWER    = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LIM  = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_WEAK_LIM = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_DIS_LIM  = CFG_IDX_W'(6);

	// Register reset values
	localparam logic [GAIN_W-1:0]    RST_SS_STIFF = 16'd25600;
	localparam logic [GAIN_W-1:0]    RST_SS_DAMP  = 16'd102;
	localparam logic [POS_LIM_W-1:0] RST_UPPER    = 32'd1342183424;
	localparam logic [POS_LIM_W-1:0] RST_LOWER    = 32'd2952849408;
	localparam logic [TRQ_LIM_W-1:0] RST_MAX_LIM  = 48'd28587587539200;
	localparam logic [TRQ_LIM_W-1:0] RST_WEAK_LIM = 48'd6597170431488;
	localparam logic [TRQ_LIM_W-1:0] RST_DIS_LIM  = 48'd0;

	typedef struct packed {
		logic [GAIN_W-1:0]    ss_stiff;
		logic [GAIN_W-1:0]    ss_damp;
		logic [POS_LIM_W-1:0] upper;
		logic [POS_LIM_W-1:0] lower;
		logic [TRQ_LIM_W-1:0] max_lim;
		logic [TRQ_LIM_W-1:0] weak_lim;
		logic [TRQ_LIM_W-1:0] dis_lim;
	} cfg_t;

	typedef struct packed {
		logic [JOINT_W-1:0]           joint;
		logic signed [DATA_WIDTH-1:0] position;
		logic signed [DATA_WIDTH-1:0] velocity;
		logic [GAIN_W-1:0]            stiffness;
		logic [GAIN_W-1:0]            damping;
		logic signed [DATA_WIDTH-1:0] target_position;
		logic signed [DATA_WIDTH-1:0] target_velocity;
		logic signed [DATA_WIDTH-1:0] feedforward;
		logic                         enable;
		logic                         weak_mode;
	} cmd_t;

	// After law and limit selection
	typedef struct packed {
		logic [JOINT_W-1:0]           joint;
		logic                         bad;
		logic [GAIN_W-1:0]            kpos;
		logic signed [ERR_W-1:0]      perr;
		logic [GAIN_W-1:0]            kvel;
		logic signed [ERR_W-1:0]      verr;
		logic signed [DATA_WIDTH-1:0] ff;
		logic signed [LIM_W-1:0]      lim;
	} sel_t;

	// After the two multiplies
	typedef struct packed {
		logic [JOINT_W-1:0]           joint;
		logic                         bad;
		logic signed [PROD_W-1:0]     ppos;
		logic signed [PROD_W-1:0]     pvel;
		logic signed [DATA_WIDTH-1:0] ff;
		logic signed [LIM_W-1:0]      lim;
	} prod_t;

	// After summing and rounding
	typedef struct packed {
		logic [JOINT_W-1:0]      joint;
		logic                    bad;
		logic signed [T_W-1:0]   t;
		logic signed [LIM_W-1:0] lim;
	} sum_t;

	typedef struct packed {
		logic [JOINT_W-1:0]           joint;
		logic signed [DATA_WIDTH-1:0] torque;
	} res_t;

endpackage

`default_nettype wire

// ===== design/jpd_cfg.sv =====
// Configuration register file for the joint PD torque block.
// Depends on jpd_pkg for widths, register indexes and reset values.
`default_nettype none

module jpd_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [jpd_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [jpd_pkg::CFG_W-1:0]     wr_data,
	output jpd_pkg::cfg_t                      cfg
);

	jpd_pkg::cfg_t cfg_q;

	// Write the addressed register; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ss_stiff <= jpd_pkg::RST_SS_STIFF;
			cfg_q.ss_damp  <= jpd_pkg::RST_SS_DAMP;
			cfg_q.upper    <= jpd_pkg::RST_UPPER;
			cfg_q.lower    <= jpd_pkg::RST_LOWER;
			cfg_q.max_lim  <= jpd_pkg::RST_MAX_LIM;
			cfg_q.weak_lim <= jpd_pkg::RST_WEAK_LIM;
			cfg_q.dis_lim  <= jpd_pkg::RST_DIS_LIM;
		end else if (wr_en) begin
			case (wr_index)
				jpd_pkg::REG_SS_STIFF: cfg_q.ss_stiff <= wr_data[jpd_pkg::GAIN_W-1:0];
				jpd_pkg::REG_SS_DAMP:  cfg_q.ss_damp  <= wr_data[jpd_pkg::GAIN_W-1:0];
				jpd_pkg::REG_UPPER:    cfg_q.upper    <= wr_data[jpd_pkg::POS_LIM_W-1:0];
				jpd_pkg::REG_LOWER:    cfg_q.lower    <= wr_data[jpd_pkg::POS_LIM_W-1:0];
				jpd_pkg::REG_MAX_LIM:  cfg_q.max_lim  <= wr_data[jpd_pkg::TRQ_LIM_W-1:0];
				jpd_pkg::REG_WEAK_LIM: cfg_q.weak_lim <= wr_data[jpd_pkg::TRQ_LIM_W-1:0];
				jpd_pkg::REG_DIS_LIM:  cfg_q.dis_lim  <= wr_data[jpd_pkg::TRQ_LIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== design/jpd_select.sv =====
// Stage 1: soft-stop test, control law operand selection and torque limit pick.
// Depends on jpd_pkg for the command and stage item types.
`default_nettype none

module jpd_select (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  jpd_pkg::cfg_t cfg,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  jpd_pkg::cmd_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output jpd_pkg::sel_t out_data
);

	logic                              v_s1;
	jpd_pkg::sel_t                     d_s1;
	jpd_pkg::sel_t                     nxt;
	logic signed [jpd_pkg::LIM_W-1:0]  up_lim;
	logic signed [jpd_pkg::LIM_W-1:0]  lo_lim;
	logic signed [jpd_pkg::ERR_W-1:0]  q_x;
	logic signed [jpd_pkg::ERR_W-1:0]  up_x;
	logic signed [jpd_pkg::ERR_W-1:0]  lo_x;
	logic signed [jpd_pkg::ERR_W-1:0]  tgt_x;
	logic signed [jpd_pkg::ERR_W-1:0]  vtgt_x;
	logic                              has_stop;
	logic                              above;
	logic                              below;
	logic                              stop_law;
	logic [jpd_pkg::TRQ_LIM_W-1:0]     lims;

	// Pick the position limits of abad or hip
	always_comb begin
		up_lim   = in_data.joint[0] ? cfg.upper[31:16] : cfg.upper[15:0];
		lo_lim   = in_data.joint[0] ? cfg.lower[31:16] : cfg.lower[15:0];
		q_x      = jpd_pkg::ERR_W'(in_data.position);
		up_x     = jpd_pkg::ERR_W'(up_lim);
		lo_x     = jpd_pkg::ERR_W'(lo_lim);
		has_stop = (in_data.joint == jpd_pkg::JOINT_ABAD) ||
			(in_data.joint == jpd_pkg::JOINT_HIP);
		above    = has_stop && (q_x > up_x);
		below    = has_stop && !above && (q_x < lo_x);
		stop_law = above || below;
	end

	// Select gains, errors and the torque limit for the law in force
	always_comb begin
		tgt_x  = above ? up_x : (below ? lo_x : jpd_pkg::ERR_W'(in_data.target_position));
		vtgt_x = stop_law ? '0 : jpd_pkg::ERR_W'(in_data.target_velocity);
		lims   = in_data.enable ? (in_data.weak_mode ? cfg.weak_lim : cfg.max_lim)
			: cfg.dis_lim;

		nxt.joint = in_data.joint;
		nxt.bad   = !(in_data.joint < jpd_pkg::JOINT_W'(jpd_pkg::JOINT_COUNT));
		nxt.kpos  = stop_law ? cfg.ss_stiff : in_data.stiffness;
		nxt.kvel  = stop_law ? cfg.ss_damp : in_data.damping;
		nxt.perr  = tgt_x - q_x;
		nxt.verr  = vtgt_x - jpd_pkg::ERR_W'(in_data.velocity);
		nxt.ff    = in_data.feedforward;
		case (in_data.joint)
			jpd_pkg::JOINT_ABAD: nxt.lim = lims[15:0];
			jpd_pkg::JOINT_HIP:  nxt.lim = lims[31:16];
			jpd_pkg::JOINT_KNEE: nxt.lim = lims[47:32];
			default:             nxt.lim = '0;
		endcase
	end

	assign in_ready = !v_s1 || out_ready;

	// Advance the valid bit whenever the stage can move
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// Load the payload on an accepted item
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_s1 <= nxt;
		end
	end

	assign out_valid = v_s1;
	assign out_data  = d_s1;

endmodule

`default_nettype wire

// ===== design/jpd_mult.sv =====
// Stage 2: position and velocity gain products, one 17x17 signed multiply each.
// Depends on jpd_pkg for the stage item types.
`default_nettype none

module jpd_mult (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  jpd_pkg::sel_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output jpd_pkg::prod_t out_data
);

	logic                             v_s2;
	jpd_pkg::prod_t                   d_s2;
	jpd_pkg::prod_t                   nxt;
	logic signed [jpd_pkg::GAIN_W:0]  kp_s;
	logic signed [jpd_pkg::GAIN_W:0]  kd_s;

	// Treat the unsigned gains as positive signed operands
	always_comb begin
		kp_s      = {1'b0, in_data.kpos};
		kd_s      = {1'b0, in_data.kvel};
		nxt.joint = in_data.joint;
		nxt.bad   = in_data.bad;
		nxt.ppos  = kp_s * in_data.perr;
		nxt.pvel  = kd_s * in_data.verr;
		nxt.ff    = in_data.ff;
		nxt.lim   = in_data.lim;
	end

	assign in_ready = !v_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (in_ready) begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_s2 <= nxt;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = d_s2;

endmodule

`default_nettype wire

// ===== design/jpd_acc.sv =====
// Stage 3: sum the terms in Q.20 and round half up to Q7.8.
// Depends on jpd_pkg for the accumulator widths and stage item types.
`default_nettype none

module jpd_acc (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  jpd_pkg::prod_t in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output jpd_pkg::sum_t  out_data
);

	localparam logic signed [jpd_pkg::ACC_W-1:0] RND_HALF =
		jpd_pkg::ACC_W'(1) <<< (jpd_pkg::RND_SH - 1);

	logic                             v_s3;
	jpd_pkg::sum_t                    d_s3;
	jpd_pkg::sum_t                    nxt;
	logic signed [jpd_pkg::ACC_W-1:0] acc;

	// Scale velocity term by 16 and feedforward by 4096, add the half LSB
	always_comb begin
		acc = jpd_pkg::ACC_W'(in_data.ppos)
			+ (jpd_pkg::ACC_W'(in_data.pvel) <<< jpd_pkg::VEL_SH)
			+ (jpd_pkg::ACC_W'(in_data.ff) <<< jpd_pkg::RND_SH)
			+ RND_HALF;
		nxt.joint = in_data.joint;
		nxt.bad   = in_data.bad;
		nxt.t     = acc[jpd_pkg::ACC_W-1:jpd_pkg::RND_SH];
		nxt.lim   = in_data.lim;
	end

	assign in_ready = !v_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (in_ready) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_s3 <= nxt;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = d_s3;

endmodule

`default_nettype wire

// ===== design/jpd_clamp.sv =====
// Stage 4 and output register: clamp to +-limit, saturate, zero bad joints.
// Depends on jpd_pkg for the stage item and result types.
`default_nettype none

module jpd_clamp (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  jpd_pkg::sum_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output jpd_pkg::res_t out_data
);

	localparam logic signed [jpd_pkg::T_W-1:0] T_MAX =
		jpd_pkg::T_W'((64'd1 << (jpd_pkg::DATA_WIDTH - 1)) - 64'd1);
	localparam logic signed [jpd_pkg::T_W-1:0] T_MIN = -T_MAX - jpd_pkg::T_W'(1);

	logic                           v_s4;
	jpd_pkg::res_t                  d_s4;
	jpd_pkg::res_t                  nxt;
	logic signed [jpd_pkg::T_W-1:0] lim_x;
	logic signed [jpd_pkg::T_W-1:0] nlim_x;
	logic signed [jpd_pkg::T_W-1:0] t_hi;
	logic signed [jpd_pkg::T_W-1:0] t_lo;
	logic signed [jpd_pkg::T_W-1:0] t_sat;

	// Upper clamp first, then lower, so a negative limit yields its negation
	always_comb begin
		lim_x  = jpd_pkg::T_W'(in_data.lim);
		nlim_x = -lim_x;
		t_hi   = (in_data.t > lim_x) ? lim_x : in_data.t;
		t_lo   = (t_hi < nlim_x) ? nlim_x : t_hi;
		if (t_lo > T_MAX) begin
			t_sat = T_MAX;
		end else if (t_lo < T_MIN) begin
			t_sat = T_MIN;
		end else begin
			t_sat = t_lo;
		end
		nxt.joint  = in_data.joint;
		nxt.torque = in_data.bad ? '0 : t_sat[jpd_pkg::DATA_WIDTH-1:0];
	end

	assign in_ready = !v_s4 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (in_ready) begin
			v_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_s4 <= nxt;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = d_s4;

endmodule

`default_nettype wire

// ===== design/joint_pd_torque_with_softstop.sv =====
// Top level of the joint PD torque controller with soft stops.
// Depends on jpd_pkg, jpd_cfg, jpd_select, jpd_mult, jpd_acc and jpd_clamp.
//
// Channel   Direction  Handshake                  Payload
// s_axis    in         s_axis_tvalid/tready       one joint command
// m_axis    out        m_axis_tvalid/tready       joint number and clamped torque
// wr        in         wr_en (no back-pressure)   register index and value
//
// One item per cycle when nothing stalls; an accepted item passes through the
// four register stages (select, multiply, sum, clamp) in order, the 17x17
// multiplies being the deepest logic between registers.
// arst_n clears the valid bits and loads the register reset values.
// A stall on m_axis holds the full stages back to the first empty one; empty stages still take items.
`default_nettype none

module joint_pd_torque_with_softstop (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// position, velocity, stiffness, damping, target_position,
	// target_velocity, feedforward (16 bits each, lowest first)
	input  wire logic [jpd_pkg::S_DATA_W-1:0]    s_axis_tdata,
	// joint [1:0], enable [2], weak_mode [3]
	input  wire logic [jpd_pkg::S_USER_W-1:0]    s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// torque [15:0]
	output logic [jpd_pkg::M_DATA_W-1:0]         m_axis_tdata,
	// joint_out [1:0]
	output logic [jpd_pkg::JOINT_W-1:0]          m_axis_tuser,
	input  wire logic                            wr_en,
	input  wire logic [jpd_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [jpd_pkg::CFG_W-1:0]       wr_data
);

	localparam int DW = jpd_pkg::DATA_WIDTH;
	localparam int GW = jpd_pkg::GAIN_W;

	jpd_pkg::cfg_t  cfg;
	jpd_pkg::cmd_t  cmd;
	jpd_pkg::sel_t  sel;
	jpd_pkg::prod_t prod;
	jpd_pkg::sum_t  sum;
	jpd_pkg::res_t  res;
	logic           sel_valid;
	logic           sel_ready;
	logic           prod_valid;
	logic           prod_ready;
	logic           sum_valid;
	logic           sum_ready;

	// Unpack the command fields
	always_comb begin
		cmd.joint           = s_axis_tuser[jpd_pkg::JOINT_W-1:0];
		cmd.enable          = s_axis_tuser[jpd_pkg::EN_BIT];
		cmd.weak_mode       = s_axis_tuser[jpd_pkg::WEAK_BIT];
		cmd.position        = s_axis_tdata[jpd_pkg::POS_LO +: DW];
		cmd.velocity        = s_axis_tdata[jpd_pkg::VEL_LO +: DW];
		cmd.stiffness       = s_axis_tdata[jpd_pkg::KP_LO +: GW];
		cmd.damping         = s_axis_tdata[jpd_pkg::KD_LO +: GW];
		cmd.target_position = s_axis_tdata[jpd_pkg::QDES_LO +: DW];
		cmd.target_velocity = s_axis_tdata[jpd_pkg::VDES_LO +: DW];
		cmd.feedforward     = s_axis_tdata[jpd_pkg::FF_LO +: DW];
	end

	jpd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	jpd_select u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (cmd),
		.out_valid (sel_valid),
		.out_ready (sel_ready),
		.out_data  (sel)
	);

	jpd_mult u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sel_valid),
		.in_ready  (sel_ready),
		.in_data   (sel),
		.out_valid (prod_valid),
		.out_ready (prod_ready),
		.out_data  (prod)
	);

	jpd_acc u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prod_valid),
		.in_ready  (prod_ready),
		.in_data   (prod),
		.out_valid (sum_valid),
		.out_ready (sum_ready),
		.out_data  (sum)
	);

	jpd_clamp u_clamp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sum_valid),
		.in_ready  (sum_ready),
		.in_data   (sum),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (res)
	);

	// Pack the result item
	assign m_axis_tdata = jpd_pkg::M_DATA_W'(res.torque);
	assign m_axis_tuser = res.joint;

endmodule

`default_nettype wire

// ===== design/jpd_checker.sv =====
// Port-level checker for the joint PD torque block, bound to the top level.
// Depends on jpd_pkg and joint_pd_torque_with_softstop_macros.svh.
`default_nettype none
`include "joint_pd_torque_with_softstop_macros.svh"

module jpd_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_axis_tready,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [jpd_pkg::M_DATA_W-1:0]    m_axis_tdata,
	input wire logic [jpd_pkg::JOINT_W-1:0]     m_axis_tuser
);

	localparam logic [jpd_pkg::JOINT_W-1:0]  JOINT_NONE = jpd_pkg::JOINT_W'(jpd_pkg::JOINT_COUNT);
	localparam logic [jpd_pkg::M_DATA_W-1:0] TRQ_MOST_NEG =
		jpd_pkg::M_DATA_W'(64'd1 << (jpd_pkg::DATA_WIDTH - 1));

	// Input back-pressure only ever comes from a stalled output item
	`JPD_ASSERT_NOW(a_ready_from_stall, clk, arst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

	// A joint that does not exist always yields zero torque
	`JPD_ASSERT_NOW(a_no_joint_zero, clk, arst_n, m_axis_tvalid && (m_axis_tuser == JOINT_NONE), m_axis_tdata == '0)

	// The symmetric clamp never lets the most negative code through
	`JPD_ASSERT_NOW(a_no_most_neg, clk, arst_n, m_axis_tvalid, m_axis_tdata != TRQ_MOST_NEG)

	// A stalled result holds
	`JPD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind joint_pd_torque_with_softstop jpd_checker u_jpd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== verif/joint_pd_torque_with_softstop_test.sv =====
// Self-checking bench for the joint PD torque block with soft stops: it drives joint
// commands and register writes and predicts each clamped torque in a tracker class.
// Needs jpd_pkg and joint_pd_torque_with_softstop only.
module joint_pd_torque_with_softstop_test;
	import jpd_pkg::*;

	// No joint has this number; the block answers with a zero torque
	localparam logic [JOINT_W-1:0]   JOINT_NONE = JOINT_W'(3);
	// Register index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE  = CFG_IDX_W'(7);
	localparam int PIPE_DEPTH      = 4;
	localparam int SETTLE          = 2 * PIPE_DEPTH;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 120;
	localparam longint TORQUE_MAX  = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;

	// Register copy, torque prediction and the queue of torques still owed
	class torque_tracker;
		cfg_t regs;
		res_t expected_torques[$];
		int   fails;
		int   commands;
		int   torques;

		function new();
			regs.ss_stiff = RST_SS_STIFF;
			regs.ss_damp  = RST_SS_DAMP;
			regs.upper    = RST_UPPER;
			regs.lower    = RST_LOWER;
			regs.max_lim  = RST_MAX_LIM;
			regs.weak_lim = RST_WEAK_LIM;
			regs.dis_lim  = RST_DIS_LIM;
			fails    = 0;
			commands = 0;
			torques  = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			case (idx)
				REG_SS_STIFF: regs.ss_stiff = value[GAIN_W-1:0];
				REG_SS_DAMP:  regs.ss_damp  = value[GAIN_W-1:0];
				REG_UPPER:    regs.upper    = value[POS_LIM_W-1:0];
				REG_LOWER:    regs.lower    = value[POS_LIM_W-1:0];
				REG_MAX_LIM:  regs.max_lim  = value[TRQ_LIM_W-1:0];
				REG_WEAK_LIM: regs.weak_lim = value[TRQ_LIM_W-1:0];
				REG_DIS_LIM:  regs.dis_lim  = value[TRQ_LIM_W-1:0];
				default: ;
			endcase
		endfunction

		function res_t predict_torque(cmd_t c);
			logic [TRQ_LIM_W-1:0] lims;
			longint q, v, kp, kd, qd, vd, ff, ks, kds, up, lo, lim, acc, t;
			int sh;
			res_t r;
			r.joint  = c.joint;
			r.torque = '0;
			if (c.joint == JOINT_NONE)
				return r;
			sh  = LIM_W * c.joint;
			q   = $signed(c.position);
			v   = $signed(c.velocity);
			kp  = longint'(c.stiffness);
			kd  = longint'(c.damping);
			qd  = $signed(c.target_position);
			vd  = $signed(c.target_velocity);
			ff  = $signed(c.feedforward);
			ks  = longint'(regs.ss_stiff);
			kds = longint'(regs.ss_damp);
			// weak mode only matters while enabled
			lims = c.enable ? (c.weak_mode ? regs.weak_lim : regs.max_lim) : regs.dis_lim;
			lim  = $signed(lims[sh +: LIM_W]);
			if (c.joint == JOINT_KNEE) begin
				up = 0;
				lo = 0;
			end else begin
				up = $signed(regs.upper[sh +: LIM_W]);
				lo = $signed(regs.lower[sh +: LIM_W]);
			end
			// soft-stop spring and damper beyond a limit, PD law otherwise; sum in Q.20
			if (c.joint != JOINT_KNEE && q > up)
				acc = ks * (up - q) - 16 * kds * v + 4096 * ff;
			else if (c.joint != JOINT_KNEE && q < lo)
				acc = ks * (lo - q) - 16 * kds * v + 4096 * ff;
			else
				acc = kp * (qd - q) + 16 * kd * (vd - v) + 4096 * ff;
			// round half up to Q7.8
			t = (acc + 2048) >>> 12;
			// clamp to the limit, then saturate to the torque width
			if (t > lim)
				t = lim;
			if (t < -lim)
				t = -lim;
			if (t > TORQUE_MAX)
				t = TORQUE_MAX;
			if (t < -TORQUE_MAX - 1)
				t = -TORQUE_MAX - 1;
			r.torque = t[DATA_WIDTH-1:0];
			return r;
		endfunction

		function void note_command(cmd_t c);
			expected_torques.push_back(predict_torque(c));
			commands++;
		endfunction

		function int pending();
			return expected_torques.size();
		endfunction

		task report_mismatch(string what);
			$display("[%0t] mismatch: %s", $time, what);
			fails++;
		endtask

		task check_torque(logic [JOINT_W-1:0] joint, logic [DATA_WIDTH-1:0] torque);
			res_t want;
			torques++;
			if (expected_torques.size() == 0) begin
				report_mismatch($sformatf("torque %0d for joint %0d with none owed",
					$signed(torque), joint));
				return;
			end
			want = expected_torques.pop_front();
			if (joint !== want.joint)
				report_mismatch($sformatf("joint_out %0d, expected %0d", joint, want.joint));
			if (torque !== want.torque)
				report_mismatch($sformatf("joint %0d torque %0d, expected %0d",
					want.joint, $signed(torque), $signed(want.torque)));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_DATA_W-1:0]   s_axis_tdata = '0;
	logic [S_USER_W-1:0]   s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_axis_tdata;
	logic [JOINT_W-1:0]    m_axis_tuser;
	logic                  wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index = '0;
	logic [CFG_W-1:0]      wr_data = '0;

	int send_idle = 0;
	int recv_idle = 0;
	int cycles = 0;
	int reg_writes = 0;
	torque_tracker tracker;

	joint_pd_torque_with_softstop DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// tdata: position, velocity, stiffness, damping, target_position,
	// target_velocity, feedforward from the lowest bit up
	function automatic logic [S_DATA_W-1:0] pack_cmd(cmd_t c);
		logic [S_DATA_W-1:0] d;
		d = '0;
		d[POS_LO  +: DATA_WIDTH] = c.position;
		d[VEL_LO  +: DATA_WIDTH] = c.velocity;
		d[KP_LO   +: GAIN_W]     = c.stiffness;
		d[KD_LO   +: GAIN_W]     = c.damping;
		d[QDES_LO +: DATA_WIDTH] = c.target_position;
		d[VDES_LO +: DATA_WIDTH] = c.target_velocity;
		d[FF_LO   +: DATA_WIDTH] = c.feedforward;
		return d;
	endfunction

	function automatic cmd_t unpack_cmd(logic [S_DATA_W-1:0] d, logic [S_USER_W-1:0] u);
		cmd_t c;
		c.joint           = u[JOINT_W-1:0];
		c.enable          = u[EN_BIT];
		c.weak_mode       = u[WEAK_BIT];
		c.position        = d[POS_LO  +: DATA_WIDTH];
		c.velocity        = d[VEL_LO  +: DATA_WIDTH];
		c.stiffness       = d[KP_LO   +: GAIN_W];
		c.damping         = d[KD_LO   +: GAIN_W];
		c.target_position = d[QDES_LO +: DATA_WIDTH];
		c.target_velocity = d[VDES_LO +: DATA_WIDTH];
		c.feedforward     = d[FF_LO   +: DATA_WIDTH];
		return c;
	endfunction

	function automatic cmd_t make_cmd(logic [JOINT_W-1:0] j, logic [DATA_WIDTH-1:0] pos,
			logic [DATA_WIDTH-1:0] vel, logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] kd,
			logic [DATA_WIDTH-1:0] qd, logic [DATA_WIDTH-1:0] vd,
			logic [DATA_WIDTH-1:0] ff, logic en, logic wk);
		cmd_t c;
		c.joint           = j;
		c.position        = pos;
		c.velocity        = vel;
		c.stiffness       = kp;
		c.damping         = kd;
		c.target_position = qd;
		c.target_velocity = vd;
		c.feedforward     = ff;
		c.enable          = en;
		c.weak_mode       = wk;
		return c;
	endfunction

	// Uniform value in [-span, span], wrapped to the field width
	function automatic logic [DATA_WIDTH-1:0] near(int span);
		return DATA_WIDTH'(int'($urandom_range(2 * span)) - span);
	endfunction

	function automatic logic [CFG_W-1:0] rand_wide();
		return CFG_W'({$urandom, $urandom});
	endfunction

	function automatic logic [TRQ_LIM_W-1:0] rand_pos_lims();
		return {16'($urandom_range(32767)), 16'($urandom_range(32767)),
			16'($urandom_range(32767))};
	endfunction

	// Mix of raw noise, moderate commands, and positions hugging the soft-stop
	// limits of abad and hip
	function automatic cmd_t random_cmd();
		cmd_t c;
		int sh;
		c = unpack_cmd(S_DATA_W'({$urandom, $urandom, $urandom, $urandom}),
			S_USER_W'($urandom));
		case ($urandom_range(3))
			0: ;
			1, 2: begin
				c.joint = ($urandom_range(15) == 0) ? JOINT_NONE : JOINT_W'($urandom_range(2));
				c.position        = near(12288);
				c.velocity        = near(2560);
				c.stiffness       = GAIN_W'($urandom_range(25600));
				c.damping         = GAIN_W'($urandom_range(1024));
				c.target_position = c.position + near(2048);
				c.target_velocity = near(2560);
				c.feedforward     = near(2560);
				c.enable          = ($urandom_range(3) != 0);
			end
			default: begin
				c.joint = $urandom_range(1) ? JOINT_HIP : JOINT_ABAD;
				sh = LIM_W * c.joint;
				c.position = ($urandom_range(1) ? tracker.regs.upper[sh +: LIM_W]
					: tracker.regs.lower[sh +: LIM_W]) + near(4);
				c.velocity    = near(2560);
				c.feedforward = near(1024);
				c.enable      = ($urandom_range(3) != 0);
			end
		endcase
		return c;
	endfunction

	// Present one item at the falling edge and hold it until accepted
	task automatic send_cmd(input cmd_t c);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pack_cmd(c);
		s_axis_tuser  <= {c.weak_mode, c.enable, c.joint};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Drop valid and wait until every owed torque has come back
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		@(posedge clk);
		tracker.set_reg(idx, value);
		reg_writes++;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic write_all(input logic [CFG_W-1:0] ss, input logic [CFG_W-1:0] sd,
			input logic [CFG_W-1:0] up, input logic [CFG_W-1:0] lo,
			input logic [CFG_W-1:0] mx, input logic [CFG_W-1:0] wk,
			input logic [CFG_W-1:0] ds);
		write_reg(REG_SS_STIFF, ss);
		write_reg(REG_SS_DAMP, sd);
		write_reg(REG_UPPER, up);
		write_reg(REG_LOWER, lo);
		write_reg(REG_MAX_LIM, mx);
		write_reg(REG_WEAK_LIM, wk);
		write_reg(REG_DIS_LIM, ds);
	endtask

	// Receiver: stall at random at the falling edge
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle);

	// Note accepted commands before checking torques on the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				tracker.note_command(unpack_cmd(s_axis_tdata, s_axis_tuser));
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_torque(m_axis_tuser, m_axis_tdata[DATA_WIDTH-1:0]);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d torques owed",
				cycles, tracker.pending());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		tracker = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int phase = 0; phase < PHASES; phase++) begin
			// idling pattern: sender light, then receiver light, then none
			if (phase == 0) begin
				send_idle = 16;
				recv_idle = 45;
			end else if (phase == 2) begin
				send_idle = 45;
				recv_idle = 16;
			end else if (phase == 4) begin
				send_idle = 0;
				recv_idle = 0;
			end

			case (phase)
				0: begin
					// reset register values: field extremes, both laws, every limit choice
					send_cmd(make_cmd(JOINT_KNEE, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
						16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0));
					send_cmd(make_cmd(JOINT_KNEE, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF,
						16'h7FFF, 16'h8000, 16'h7FFF, 1'b1, 1'b0));
					send_cmd(make_cmd(JOINT_KNEE, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF,
						16'h8000, 16'h7FFF, 16'h8000, 1'b1, 1'b0));
					// abad just past, and exactly at, each limit
					send_cmd(make_cmd(JOINT_ABAD, 16'h1801, 16'h0100, 16'h1000, 16'h0080,
						16'h0000, 16'h0000, 16'h0040, 1'b1, 1'b0));
					send_cmd(make_cmd(JOINT_ABAD, 16'h1800, 16'h0100, 16'h1000, 16'h0080,
						16'h0000, 16'h0000, 16'h0040, 1'b1, 1'b0));
					send_cmd(make_cmd(JOINT_ABAD, 16'hE7FF, 16'hFF00, 16'h1000, 16'h0080,
						16'h0000, 16'h0000, 16'hFFC0, 1'b1, 1'b0));
					send_cmd(make_cmd(JOINT_ABAD, 16'hE800, 16'hFF00, 16'h1000, 16'h0080,
						16'h0000, 16'h0000, 16'hFFC0, 1'b1, 1'b0));
					// hip at the position extremes and at its upper limit
					send_cmd(make_cmd(JOINT_HIP, 16'h7FFF, 16'h7FFF, 16'h0100, 16'h0100,
						16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0));
					send_cmd(make_cmd(JOINT_HIP, 16'h8000, 16'h8000, 16'h0100, 16'h0100,
						16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0));
					send_cmd(make_cmd(JOINT_HIP, 16'h5000, 16'h0000, 16'h0200, 16'h0010,
						16'h4000, 16'h0000, 16'h0000, 1'b1, 1'b0));
					// no such joint
					send_cmd(make_cmd(JOINT_NONE, 16'h1234, 16'h5678, 16'hFFFF, 16'hFFFF,
						16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1));
					// weak bit while disabled, weak when enabled, plain disabled
					send_cmd(make_cmd(JOINT_KNEE, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
						16'h0000, 16'h0000, 16'h7FFF, 1'b0, 1'b1));
					send_cmd(make_cmd(JOINT_KNEE, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
						16'h0000, 16'h0000, 16'h7FFF, 1'b1, 1'b1));
					send_cmd(make_cmd(JOINT_HIP, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
						16'h0000, 16'h0000, 16'h7FFF, 1'b0, 1'b0));
					send_cmd(make_cmd(JOINT_KNEE, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
						16'h0000, 16'h0000, 16'h8000, 1'b1, 1'b0));
					// rounding: exactly minus a half, plus a half, one and a half
					send_cmd(make_cmd(JOINT_KNEE, 16'h0800, 16'h0000, 16'h0001, 16'h0000,
						16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0));
					send_cmd(make_cmd(JOINT_KNEE, 16'h0000, 16'h0000, 16'h0001, 16'h0000,
						16'h0800, 16'h0000, 16'h0000, 1'b1, 1'b0));
					send_cmd(make_cmd(JOINT_KNEE, 16'h0000, 16'h0000, 16'h0003, 16'h0000,
						16'h0800, 16'h0000, 16'h0000, 1'b1, 1'b0));
				end
				1: begin
					// top extremes, negative weak and disabled limits, spare index
					write_all(48'hFFFF, 48'hFFFF, 48'h7FFF_7FFF, 48'h8000_8000,
						48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'hFFFF_FFFF_FFFF);
					write_reg(REG_SPARE, rand_wide());
					send_cmd(make_cmd(JOINT_KNEE, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000,
						16'h7FFF, 16'h0000, 16'h7FFF, 1'b1, 1'b1));
					send_cmd(make_cmd(JOINT_KNEE, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0000,
						16'h8000, 16'h0000, 16'h8000, 1'b1, 1'b1));
					send_cmd(make_cmd(JOINT_HIP, 16'h0100, 16'h0000, 16'h0100, 16'h0000,
						16'h0000, 16'h0000, 16'h8000, 1'b0, 1'b0));
					send_cmd(make_cmd(JOINT_ABAD, 16'h8000, 16'h0000, 16'hFFFF, 16'hFFFF,
						16'h7FFF, 16'h8000, 16'h8000, 1'b1, 1'b0));
				end
				2: write_all(48'h0, 48'h0, 48'h0, 48'h0, 48'h7FFF_7FFF_7FFF, 48'h0, 48'h0);
				3: write_all(CFG_W'($urandom_range(65535)), CFG_W'($urandom_range(2048)),
					CFG_W'({16'($urandom_range(16383)), 16'($urandom_range(16383))}),
					CFG_W'({16'(-int'($urandom_range(16383))),
						16'(-int'($urandom_range(16383)))}),
					rand_pos_lims(), rand_pos_lims(), rand_pos_lims());
				default: write_all(rand_wide(), rand_wide(), rand_wide(), rand_wide(),
					rand_wide(), rand_wide(), rand_wide());
			endcase

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// hold the sender once until the pipeline has emptied
				if (phase == 2 && n == ITEMS_PER_PHASE / 2)
					drain();
				send_cmd(random_cmd());
			end
			drain();
		end

		if (tracker.pending() != 0)
			tracker.report_mismatch($sformatf("%0d torques never came", tracker.pending()));
		$display("Checked %0d torques from %0d joint commands under %0d settings and %0d writes,",
			tracker.torques, tracker.commands, PHASES, reg_writes);
		$display("with soft stops, both limit edges, joint three and three stall patterns.");
		if (tracker.fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
